### rtl/ttt_pkg.sv
// Package with the sizes, codes and state type of the tap tempo tracker.
`default_nettype none

package ttt_pkg;

  localparam int HISTORY_LEN = 8;
  localparam int AVG_SHIFT   = 6;

  localparam int TIME_W = 16;
  localparam int DEV_W  = 8;
  localparam int PTR_W  = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
  localparam int CNT_W  = $clog2(HISTORY_LEN + 1);
  localparam int SUM_W  = TIME_W + $clog2(HISTORY_LEN) + 1;
  localparam int DIVS_W = TIME_W - AVG_SHIFT;
  localparam int DCNT_W = $clog2(SUM_W);

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [DEV_W-1:0] DEV_MAX = {DEV_W{1'b1}};

  typedef enum logic {
    REG_MAX_STEP  = 1'b0,
    REG_DEV_LIMIT = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAST,
    S_DEV,
    S_EVICT,
    S_AVG,
    S_OUT
  } state_e;

endpackage

`default_nettype wire

### rtl/tap_tempo_tracker.sv
// Top level of the tap tempo tracker: interval ring, control sequencer and register port.
//
//   port group  | direction | beat
//   tap in      | in        | tap_time_i under in_valid_i / in_ready_o
//   result out  | out       | reset_event_o, average_interval_o, stored_count_o,
//               |           | deviation_value_o under out_valid_o / out_ready_i
//   registers   | in/out    | APB writes and reads of max_step_length, deviation_limit
//
// A tap that joins an active cycle passes twice through the one-bit-per-cycle divider, for its
// deviation and then for the new average; one that stores the first interval or restarts an
// active cycle passes through it once, and one that comes when no cycle is active not at all.
// The interval ring is a one-port synchronous memory, read in the cycle before its use.
// Reset clears all control state; the ring holds no valid data until written.
// A new tap is taken while the previous result still waits in the output register; its own
// result then holds the sequencer until that beat has left.
`default_nettype none

module tap_tempo_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ttt_pkg::TIME_W-1:0]    tap_time_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          reset_event_o,
  output logic [ttt_pkg::TIME_W-1:0]    average_interval_o,
  output logic [ttt_pkg::CNT_W-1:0]     stored_count_o,
  output logic [ttt_pkg::DEV_W-1:0]     deviation_value_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ttt_pkg::ADDR_W-1:0]    paddr,
  input  logic [ttt_pkg::DATA_W-1:0]    pwdata,
  output logic [ttt_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import ttt_pkg::*;

  state_e            state_q, state_d;
  logic [TIME_W-1:0] prev_q, prev_d;
  logic [TIME_W-1:0] diff_q, diff_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [TIME_W-1:0] avg_q, avg_d;
  logic              await_q, await_d;
  logic              rev_q, rev_d;
  logic [DEV_W-1:0]  dev_q, dev_d;
  logic [TIME_W-1:0] max_step_q;
  logic [DEV_W-1:0]  dev_limit_q;

  logic              ov_q, ov_d;
  logic              o_rev_q, o_rev_d;
  logic [TIME_W-1:0] o_avg_q, o_avg_d;
  logic [CNT_W-1:0]  o_cnt_q, o_cnt_d;
  logic [DEV_W-1:0]  o_dev_q, o_dev_d;

  logic [TIME_W-1:0] ring_mem [HISTORY_LEN];
  logic [TIME_W-1:0] mem_rdata_q;
  logic              mem_re, mem_we;
  logic [PTR_W-1:0]  mem_raddr;
  logic [PTR_W-1:0]  head_nxt;

  logic              div_start, div_busy, div_done;
  logic [SUM_W-1:0]  div_dividend, div_quotient;
  logic [DIVS_W-1:0] div_divisor;

  logic [TIME_W-1:0] absdiff;
  logic [DIVS_W-1:0] avg_scaled;
  logic [DEV_W-1:0]  dev_sat;
  logic [TIME_W-1:0] evict;
  logic              cfg_wr;

  assign head_nxt   = (head_q == PTR_W'(HISTORY_LEN - 1)) ? '0 : head_q + 1'b1;
  assign absdiff    = (diff_q >= mem_rdata_q) ? diff_q - mem_rdata_q : mem_rdata_q - diff_q;
  assign avg_scaled = DIVS_W'(avg_q >> AVG_SHIFT);
  assign dev_sat    = (div_quotient > SUM_W'(DEV_MAX)) ? DEV_MAX : DEV_W'(div_quotient);
  assign evict      = (fill_q == CNT_W'(HISTORY_LEN)) ? mem_rdata_q : '0;

  always_comb begin
    state_d      = state_q;
    prev_d       = prev_q;
    diff_d       = diff_q;
    head_d       = head_q;
    fill_d       = fill_q;
    sum_d        = sum_q;
    avg_d        = avg_q;
    await_d      = await_q;
    rev_d        = rev_q;
    dev_d        = dev_q;
    ov_d         = ov_q && !out_ready_i;
    o_rev_d      = o_rev_q;
    o_avg_d      = o_avg_q;
    o_cnt_d      = o_cnt_q;
    o_dev_d      = o_dev_q;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    mem_raddr    = head_q;
    div_start    = 1'b0;
    div_dividend = SUM_W'(absdiff);
    div_divisor  = (avg_scaled == '0) ? DIVS_W'(1) : avg_scaled;
    in_ready_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          diff_d  = tap_time_i - prev_q;
          prev_d  = tap_time_i;
          rev_d   = 1'b0;
          dev_d   = '0;
          mem_re  = 1'b1;
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        if (fill_q != '0) begin
          div_start = 1'b1;
          state_d   = S_DEV;
        end else if (!await_q && diff_q < max_step_q) begin
          mem_re    = 1'b1;
          mem_raddr = head_nxt;
          state_d   = S_EVICT;
        end else begin
          await_d = 1'b0;
          rev_d   = 1'b1;
          state_d = S_OUT;
        end
      end
      S_DEV: begin
        if (div_done) begin
          dev_d = dev_sat;
          if (dev_sat < dev_limit_q) begin
            mem_re    = 1'b1;
            mem_raddr = head_nxt;
            state_d   = S_EVICT;
          end else begin
            fill_d  = '0;
            sum_d   = '0;
            avg_d   = '0;
            rev_d   = 1'b1;
            state_d = S_OUT;
          end
        end
      end
      S_EVICT: begin
        mem_we       = 1'b1;
        head_d       = head_nxt;
        fill_d       = (fill_q == CNT_W'(HISTORY_LEN)) ? fill_q : fill_q + 1'b1;
        sum_d        = sum_q + SUM_W'(diff_q) - SUM_W'(evict);
        div_start    = 1'b1;
        div_dividend = sum_d + SUM_W'(fill_d >> 1);
        div_divisor  = DIVS_W'(fill_d);
        state_d      = S_AVG;
      end
      S_AVG: begin
        if (div_done) begin
          avg_d   = TIME_W'(div_quotient);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          o_rev_d = rev_q;
          o_avg_d = avg_q;
          o_cnt_d = fill_q;
          o_dev_d = dev_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      prev_q  <= '0;
      head_q  <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
      avg_q   <= '0;
      await_q <= 1'b1;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      prev_q  <= prev_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      sum_q   <= sum_d;
      avg_q   <= avg_d;
      await_q <= await_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q  <= diff_d;
    rev_q   <= rev_d;
    dev_q   <= dev_d;
    o_rev_q <= o_rev_d;
    o_avg_q <= o_avg_d;
    o_cnt_q <= o_cnt_d;
    o_dev_q <= o_dev_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[head_nxt] <= diff_q;
    end
    if (mem_re) begin
      mem_rdata_q <= ring_mem[mem_raddr];
    end
  end

  ttt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q  <= '0;
      dev_limit_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_MAX_STEP:  max_step_q  <= pwdata[TIME_W-1:0];
        REG_DEV_LIMIT: dev_limit_q <= pwdata[DEV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_MAX_STEP:  prdata = DATA_W'(max_step_q);
      REG_DEV_LIMIT: prdata = DATA_W'(dev_limit_q);
      default:       prdata = '0;
    endcase
  end

  assign pready             = 1'b1;
  assign out_valid_o        = ov_q;
  assign reset_event_o      = o_rev_q;
  assign average_interval_o = o_avg_q;
  assign stored_count_o     = o_cnt_q;
  assign deviation_value_o  = o_dev_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(HISTORY_LEN))
    else $error("history count exceeds the ring depth");
  a_empty_no_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q == '0 |-> avg_q == '0 && sum_q == '0)
    else $error("empty history with a nonzero sum or average");
  a_restart_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reset_event_o |-> stored_count_o == '0 && average_interval_o == '0)
    else $error("restart beat reports a nonempty history");
  a_div_idle_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_OUT) |-> !div_busy)
    else $error("divider busy outside a division step");

endmodule

`default_nettype wire

### rtl/ttt_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module ttt_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ttt_pkg::SUM_W-1:0]   dividend_i,
  input  logic [ttt_pkg::DIVS_W-1:0]  divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [ttt_pkg::SUM_W-1:0]   quotient_o
);
  import ttt_pkg::*;

  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [DIVS_W-1:0] rem_q, rem_d;
  logic [DIVS_W-1:0] dvs_q, dvs_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIVS_W:0]   trial;
  logic              fits;

  always_comb begin
    trial  = {rem_q, quo_q[SUM_W-1]};
    fits   = (trial >= {1'b0, dvs_q});
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = DCNT_W'(SUM_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[SUM_W-2:0], fits};
      rem_d = fits ? DIVS_W'(trial - {1'b0, dvs_q}) : DIVS_W'(trial);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a finished run");
  a_no_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> divisor_i != '0)
    else $error("divider started with a zero divisor");

endmodule

`default_nettype wire

### bench/tb.sv
// Testbench of the tap tempo tracker: directed and random taps checked by a tempo predictor.
`timescale 1ns / 100ps

module tb;
  import ttt_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;

  typedef struct packed {
    logic              restarted;
    logic [TIME_W-1:0] mean;
    logic [CNT_W-1:0]  count;
    logic [DEV_W-1:0]  dev;
  } tempo_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [TIME_W-1:0] tap_time_i;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              reset_event_o;
  logic [TIME_W-1:0] average_interval_o;
  logic [CNT_W-1:0]  stored_count_o;
  logic [DEV_W-1:0]  deviation_value_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  tap_tempo_tracker dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .tap_time_i         (tap_time_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .reset_event_o      (reset_event_o),
    .average_interval_o (average_interval_o),
    .stored_count_o     (stored_count_o),
    .deviation_value_o  (deviation_value_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // Tempo state as the tracker should hold it.
  logic [TIME_W-1:0] last_tap      = '0;
  logic [TIME_W-1:0] intervals [HISTORY_LEN];
  int unsigned       head          = 0;
  int unsigned       filled        = 0;
  logic              first_pending = 1'b1;
  logic [TIME_W-1:0] cfg_max_step  = '0;
  logic [DEV_W-1:0]  cfg_dev_limit = '0;

  tempo_t      pending_tempo [$];
  tempo_t      due;
  int unsigned taps_sent  = 0;
  int unsigned errors     = 0;
  logic        src_idles  = 1'b1;
  logic        sink_idles = 1'b1;
  int unsigned hold_req   = 0;
  int unsigned stall_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    errors++;
    if (errors <= 50) $display("mismatch on %s: got %0d, expected %0d", what, got, want);
  endtask

  function automatic int unsigned ring_mean();
    int unsigned sum;
    int unsigned pos;
    sum = 0;
    pos = head;
    if (filled == 0) return 0;
    for (int unsigned k = 0; k < filled; k++) begin
      sum += intervals[pos];
      pos = (pos == 0) ? HISTORY_LEN - 1 : pos - 1;
    end
    return (sum + filled / 2) / filled;
  endfunction

  function automatic void store_interval(input logic [TIME_W-1:0] span);
    head = (head + 1) % HISTORY_LEN;
    intervals[head] = span;
    if (filled < HISTORY_LEN) filled++;
  endfunction

  function automatic tempo_t track_tap(input logic [TIME_W-1:0] stamp);
    tempo_t            r;
    logic [TIME_W-1:0] span;
    int unsigned       prior;
    int unsigned       spread;
    int unsigned       divisor;
    int unsigned       quot;
    r = '0;
    span = stamp - last_tap;
    if (filled > 0) begin
      prior = intervals[head];
      spread = (span >= prior) ? span - prior : prior - span;
      divisor = ring_mean() >> AVG_SHIFT;
      if (divisor == 0) divisor = 1;
      quot = spread / divisor;
      r.dev = (quot > DEV_MAX) ? DEV_MAX : quot[DEV_W-1:0];
      if (r.dev < cfg_dev_limit) begin
        store_interval(span);
      end else begin
        filled = 0;
        r.restarted = 1'b1;
      end
    end else if (!first_pending && span < cfg_max_step) begin
      store_interval(span);
    end else begin
      first_pending = 1'b0;
      r.restarted = 1'b1;
    end
    last_tap = stamp;
    r.mean = TIME_W'(ring_mean());
    r.count = CNT_W'(filled);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic send_tap(input logic [TIME_W-1:0] stamp);
    int unsigned pause;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    tap_time_i <= stamp;
    do @(posedge clk_i); while (!in_ready_o);
    pending_tempo.push_back(track_tap(stamp));
    taps_sent++;
    pause = src_idles ? pick_gap() : 0;
    if (pause > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (pause - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_tempo.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_reg(input reg_idx_e idx, input logic [DATA_W-1:0] want);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) flag_mismatch(idx.name(), prdata, want);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_reg(input reg_idx_e idx, input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_MAX_STEP:  cfg_max_step = value[TIME_W-1:0];
      REG_DEV_LIMIT: cfg_dev_limit = value[DEV_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_reg(idx, value);
  endtask

  task automatic play_tempo(input int unsigned n);
    int unsigned       period;
    int unsigned       jit;
    logic [TIME_W-1:0] stamp;
    period = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 120) : $urandom_range(120, 9000);
    stamp = $urandom;
    repeat (n) begin
      jit = $urandom_range(0, period / 8);
      if ($urandom_range(0, 1)) stamp = stamp + period + jit;
      else stamp = stamp + period - jit;
      if ($urandom_range(0, 19) == 0) stamp = stamp + $urandom_range(0, 3 * period);
      send_tap(stamp);
    end
  endtask

  task automatic play_noise(input int unsigned n);
    repeat (n) send_tap($urandom);
  endtask

  task automatic pick_settings();
    case ($urandom_range(0, 5))
      0:       set_reg(REG_MAX_STEP, 0);
      1:       set_reg(REG_MAX_STEP, 16'hFFFF);
      default: set_reg(REG_MAX_STEP, $urandom_range(2000, 65535));
    endcase
    case ($urandom_range(0, 5))
      0:       set_reg(REG_DEV_LIMIT, 0);
      1:       set_reg(REG_DEV_LIMIT, 8'hFF);
      default: set_reg(REG_DEV_LIMIT, $urandom_range(4, 254));
    endcase
  endtask

  task automatic test_power_on();
    check_reg(REG_MAX_STEP, 0);
    check_reg(REG_DEV_LIMIT, 0);
    send_tap(16'h0000);
    send_tap(16'hFFFF);
    send_tap(16'h0001);
    drain();
  endtask

  task automatic test_short_intervals();
    set_reg(REG_MAX_STEP, 16'hFFFF);
    set_reg(REG_DEV_LIMIT, 8'hFF);
    send_tap(16'd5000);
    send_tap(16'd5010);
    send_tap(16'd5020);
    send_tap(16'd5020);
    send_tap(16'd5030);
    send_tap(16'd40000);
    send_tap(16'd40010);
    drain();
  endtask

  task automatic test_wrap_and_fill();
    logic [TIME_W-1:0] stamp;
    set_reg(REG_DEV_LIMIT, 8'd128);
    stamp = 16'd60000;
    repeat (9) begin
      stamp = stamp + 16'd700;
      send_tap(stamp);
    end
    repeat (3) begin
      stamp = stamp + 16'hFFFE;
      send_tap(stamp);
    end
    drain();
  endtask

  task automatic test_limits();
    set_reg(REG_MAX_STEP, 16'd500);
    set_reg(REG_DEV_LIMIT, 8'd0);
    send_tap(16'd20000);
    send_tap(16'd20500);
    send_tap(16'd20999);
    send_tap(16'd21498);
    drain();
  endtask

  task automatic test_backpressure();
    set_reg(REG_MAX_STEP, 16'hFFFF);
    set_reg(REG_DEV_LIMIT, 8'hFF);
    src_idles = 1'b0;
    sink_idles = 1'b0;
    hold_req = 400;
    play_tempo(30);
    drain();
  endtask

  task automatic test_random_taps(input int unsigned target);
    int unsigned stop_at;
    stop_at = taps_sent + target;
    while (taps_sent < stop_at) begin
      drain();
      pick_settings();
      repeat (4) begin
        src_idles = ($urandom_range(0, 3) != 0);
        sink_idles = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 4) == 0) play_noise($urandom_range(1, 8));
        else play_tempo($urandom_range(3, 24));
      end
    end
    drain();
  endtask

  // The sink drops ready for random stretches and for any long hold-off requested.
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      stall_left = hold_req;
      hold_req = 0;
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if (sink_idles) stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_tempo.size() == 0) begin
        flag_mismatch("result beat with no tap waiting", 1, 0);
      end else begin
        due = pending_tempo.pop_front();
        if (reset_event_o !== due.restarted)
          flag_mismatch("reset_event", reset_event_o, due.restarted);
        if (average_interval_o !== due.mean)
          flag_mismatch("average_interval", average_interval_o, due.mean);
        if (stored_count_o !== due.count)
          flag_mismatch("stored_count", stored_count_o, due.count);
        if (deviation_value_o !== due.dev)
          flag_mismatch("deviation_value", deviation_value_o, due.dev);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    tap_time_i  = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_power_on();
    test_short_intervals();
    test_wrap_and_fill();
    test_limits();
    test_backpressure();
    test_random_taps(1150);

    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
rtl/ttt_pkg.sv
rtl/ttt_div.sv
rtl/tap_tempo_tracker.sv
bench/tb.sv
